[rtl/prs_pkg.sv]
`timescale 1ns / 1ps

package prs_pkg;

    localparam int VALUE_W  = 32;
    localparam int WEIGHT_W = 16;
    localparam int INDEX_W  = 10;
    localparam int SUM_W    = 28;
    localparam int SCORE_W  = 16;
    localparam int FRAC_SH  = 16;
    localparam int QUO_W    = SUM_W + FRAC_SH;
    localparam int DIV_STEPS = QUO_W;
    localparam int STEP_W   = $clog2(DIV_STEPS);
    localparam int CFG_IDX_W = 2;

    localparam logic [SUM_W-1:0]   SUM_MAX   = {SUM_W{1'b1}};
    localparam logic [SCORE_W-1:0] SCORE_MAX = {SCORE_W{1'b1}};

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WEIGHTED_MODE    = 2'd0,
        REG_CLASS_ONE_TOTAL  = 2'd1,
        REG_CLASS_ZERO_TOTAL = 2'd2,
        REG_PASS_THRESHOLD   = 2'd3
    } prs_reg_t;

    typedef struct packed {
        logic [SUM_W-1:0]   class_one_total;
        logic [SUM_W-1:0]   class_zero_total;
        logic [SCORE_W-1:0] pass_threshold;
    } prs_cfg_t;

    // one finished pair waiting for the divider
    typedef struct packed {
        logic [SUM_W-1:0]   one_sum;
        logic [SUM_W-1:0]   zero_sum;
        logic [INDEX_W-1:0] first_index;
        logic [INDEX_W-1:0] second_index;
    } prs_job_t;

    typedef struct packed {
        logic [SUM_W-1:0] rem;
        logic [QUO_W-1:0] quo;
    } prs_div_t;

    typedef enum logic [1:0] {
        B_IDLE   = 2'd0,
        B_DIV    = 2'd1,
        B_FINISH = 2'd2
    } prs_back_state_t;

endpackage

[rtl/prs_sample_if.sv]
`timescale 1ns / 1ps

interface prs_sample_if
    import prs_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic signed [VALUE_W-1:0]  first_value;
    logic signed [VALUE_W-1:0]  second_value;
    logic                       label;
    logic [WEIGHT_W-1:0]        weight;
    logic [INDEX_W-1:0]         first_index;
    logic [INDEX_W-1:0]         second_index;
    logic                       last_sample;

    modport source
    (
        output valid, first_value, second_value, label, weight,
               first_index, second_index, last_sample,
        input  ready
    );

    modport sink
    (
        input  valid, first_value, second_value, label, weight,
               first_index, second_index, last_sample,
        output ready
    );
endinterface

[rtl/prs_score_if.sv]
`timescale 1ns / 1ps

interface prs_score_if
    import prs_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [SCORE_W-1:0]   pair_score;
    logic [INDEX_W-1:0]   lead_index;
    logic [INDEX_W-1:0]   trail_index;
    logic                 passes;

    modport source
    (
        output valid, pair_score, lead_index, trail_index, passes,
        input  ready
    );

    modport sink
    (
        input  valid, pair_score, lead_index, trail_index, passes,
        output ready
    );
endinterface

[rtl/prs_front.sv]
`timescale 1ns / 1ps

module prs_front
    import prs_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    prs_sample_if.sink          samples,
    input  logic                weighted_mode,
    input  logic                full,
    output logic                push,
    output prs_job_t            job
);

    logic [SUM_W-1:0] one_sum_reg, one_sum_next;
    logic [SUM_W-1:0] zero_sum_reg, zero_sum_next;
    logic             xfer;
    logic             below;
    logic [SUM_W-1:0] inc;
    logic [SUM_W:0]   one_add, zero_add;
    logic [SUM_W-1:0] one_acc, zero_acc;

    assign samples.ready = !full;
    assign xfer  = samples.valid && samples.ready;
    assign below = samples.first_value < samples.second_value;
    assign inc   = weighted_mode ? SUM_W'(samples.weight) : SUM_W'(1);

    always_comb
    begin
        one_add  = {1'b0, one_sum_reg} + {1'b0, inc};
        zero_add = {1'b0, zero_sum_reg} + {1'b0, inc};
        one_acc  = one_sum_reg;
        zero_acc = zero_sum_reg;
        if (below && samples.label)
        begin
            one_acc = one_add[SUM_W] ? SUM_MAX : one_add[SUM_W-1:0];
        end
        if (below && !samples.label)
        begin
            zero_acc = zero_add[SUM_W] ? SUM_MAX : zero_add[SUM_W-1:0];
        end
    end

    always_comb
    begin
        one_sum_next  = one_sum_reg;
        zero_sum_next = zero_sum_reg;
        if (xfer)
        begin
            one_sum_next  = samples.last_sample ? '0 : one_acc;
            zero_sum_next = samples.last_sample ? '0 : zero_acc;
        end
    end

    // the last sample counts itself before the pair is handed on
    assign push             = xfer && samples.last_sample;
    assign job.one_sum      = one_acc;
    assign job.zero_sum     = zero_acc;
    assign job.first_index  = samples.first_index;
    assign job.second_index = samples.second_index;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            one_sum_reg  <= '0;
            zero_sum_reg <= '0;
        end
        else
        begin
            one_sum_reg  <= one_sum_next;
            zero_sum_reg <= zero_sum_next;
        end
    end

    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> (one_sum_reg == '0 && zero_sum_reg == '0))
        else $error("pair sums not cleared after last sample");

endmodule

[rtl/prs_queue.sv]
`timescale 1ns / 1ps

module prs_queue
    import prs_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  prs_job_t  push_job,
    input  logic      pop,
    output prs_job_t  pop_job,
    output logic      full,
    output logic      empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    prs_job_t         entries_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full    = count_reg == CNT_W'(DEPTH);
    assign empty   = count_reg == '0;
    assign pop_job = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && empty))
        else $error("pop from empty queue");

endmodule

[rtl/prs_back.sv]
`timescale 1ns / 1ps

module prs_back
    import prs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  prs_cfg_t    cfg,
    input  logic        empty,
    input  prs_job_t    job,
    output logic        pop,
    prs_score_if.source scores
);

    prs_back_state_t    state_reg, state_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    prs_div_t           div_one_reg, div_one_next;
    prs_div_t           div_zero_reg, div_zero_next;
    logic [INDEX_W-1:0] first_idx_reg, second_idx_reg;
    logic               out_valid_reg, out_valid_next;
    logic [SCORE_W-1:0] score_reg;
    logic [INDEX_W-1:0] lead_reg, trail_reg;
    logic               passes_reg;

    logic               start, stepping, load;
    logic [QUO_W-1:0]   frac_one, frac_zero, diff;
    logic               keep_order;
    logic [SCORE_W-1:0] score;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    function automatic prs_div_t div_step(prs_div_t cur, logic [SUM_W-1:0] divisor);
        logic [SUM_W:0] shifted;
        logic [SUM_W:0] trial;
        prs_div_t       res;
        shifted  = {cur.rem, cur.quo[QUO_W-1]};
        trial    = shifted - {1'b0, divisor};
        res.rem  = trial[SUM_W] ? shifted[SUM_W-1:0] : trial[SUM_W-1:0];
        res.quo  = {cur.quo[QUO_W-2:0], !trial[SUM_W]};
        return res;
    endfunction

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (!empty)
                begin
                    state_next = B_DIV;
                end
            end
            B_DIV:
            begin
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                begin
                    state_next = B_FINISH;
                end
            end
            B_FINISH:
            begin
                if (!out_valid_reg || scores.ready)
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_comb
    begin
        start    = 1'b0;
        stepping = 1'b0;
        load     = 1'b0;
        unique case (state_reg)
            B_IDLE:   start    = !empty;
            B_DIV:    stepping = 1'b1;
            B_FINISH: load     = !out_valid_reg || scores.ready;
            default:  start    = 1'b0;
        endcase
    end

    assign pop = start;

    always_comb
    begin
        step_next     = step_reg;
        div_one_next  = div_one_reg;
        div_zero_next = div_zero_reg;
        if (start)
        begin
            step_next         = '0;
            div_one_next.rem  = '0;
            div_one_next.quo  = {job.one_sum, FRAC_SH'(0)};
            div_zero_next.rem = '0;
            div_zero_next.quo = {job.zero_sum, FRAC_SH'(0)};
        end
        else if (stepping)
        begin
            step_next     = step_reg + STEP_W'(1);
            div_one_next  = div_step(div_one_reg, cfg.class_one_total);
            div_zero_next = div_step(div_zero_reg, cfg.class_zero_total);
        end
    end

    // zero total gives a zero fraction
    always_comb
    begin
        frac_one   = (cfg.class_one_total == '0) ? '0 : div_one_reg.quo;
        frac_zero  = (cfg.class_zero_total == '0) ? '0 : div_zero_reg.quo;
        keep_order = frac_one >= frac_zero;
        diff       = keep_order ? frac_one - frac_zero : frac_zero - frac_one;
        score      = (|diff[QUO_W-1:SCORE_W]) ? SCORE_MAX : diff[SCORE_W-1:0];
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (scores.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        div_one_reg  <= div_one_next;
        div_zero_reg <= div_zero_next;
        if (start)
        begin
            first_idx_reg  <= job.first_index;
            second_idx_reg <= job.second_index;
        end
        if (load)
        begin
            score_reg  <= score;
            lead_reg   <= keep_order ? first_idx_reg : second_idx_reg;
            trail_reg  <= keep_order ? second_idx_reg : first_idx_reg;
            passes_reg <= score >= cfg.pass_threshold;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign scores.valid       = out_valid_reg;
    assign scores.pair_score  = score_reg;
    assign scores.lead_index  = lead_reg;
    assign scores.trail_index = trail_reg;
    assign scores.passes      = passes_reg;

    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == B_FINISH)
        else $error("result raised outside finish state");

    a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> state_reg == B_DIV && step_reg == '0)
        else $error("divider did not start on pop");

endmodule

[rtl/pair_rank_score.sv]
`timescale 1ns / 1ps

// Scores one feature pair for a top-scoring-pair classifier. Samples stream in
// on "samples", one per clock while the pair queue has room; each sample where
// first_value < second_value (signed) adds the weight (weighted mode) or 1 to
// its class sum, saturating at 2^28-1. The sample with last_sample set closes
// the pair: both sums go into a queue of QUEUE_DEPTH pairs and the sums restart
// at zero in the same cycle. Behind the queue a pair of restoring dividers,
// one quotient bit per cycle, form floor(sum * 65536 / total) for each class;
// a pair's result goes through a load, 44 divide steps and a finish state that
// waits until the previous result is taken; the divider takes no new pair
// until it finishes, while samples keep flowing at one per cycle until the
// queue fills. The result gives |frac1 - frac0| saturated to 65535, the pair
// indices of the last sample (swapped when the class-zero fraction is larger)
// and passes = score >= pass threshold. A zero total makes that fraction zero.
// Registers on cfg_index: 0 weighted_mode, 1 class_one_total,
// 2 class_zero_total, 3 pass threshold; write them only while the block is idle.
module pair_rank_score
    import prs_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SUM_W-1:0]     cfg_data,
    prs_sample_if.sink           samples,
    prs_score_if.source          scores
);

    logic               weighted_mode_reg;
    logic [SUM_W-1:0]   one_total_reg;
    logic [SUM_W-1:0]   zero_total_reg;
    logic [SCORE_W-1:0] threshold_reg;

    prs_cfg_t cfg;
    prs_job_t push_job, pop_job;
    logic     push, pop, full, empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weighted_mode_reg <= 1'b0;
            one_total_reg     <= SUM_W'(1);
            zero_total_reg    <= SUM_W'(1);
            threshold_reg     <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_WEIGHTED_MODE:    weighted_mode_reg <= cfg_data[0];
                REG_CLASS_ONE_TOTAL:  one_total_reg     <= cfg_data;
                REG_CLASS_ZERO_TOTAL: zero_total_reg    <= cfg_data;
                REG_PASS_THRESHOLD:   threshold_reg     <= cfg_data[SCORE_W-1:0];
                default:              threshold_reg     <= threshold_reg;
            endcase
        end
    end

    assign cfg.class_one_total  = one_total_reg;
    assign cfg.class_zero_total = zero_total_reg;
    assign cfg.pass_threshold   = threshold_reg;

    prs_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .samples       (samples),
        .weighted_mode (weighted_mode_reg),
        .full          (full),
        .push          (push),
        .job           (push_job)
    );

    prs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .pop_job  (pop_job),
        .full     (full),
        .empty    (empty)
    );

    prs_back u_back
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .empty  (empty),
        .job    (pop_job),
        .pop    (pop),
        .scores (scores)
    );

endmodule

[sim/pair_rank_score_test.sv]
`timescale 1ns / 1ps

module pair_rank_score_test
    import prs_pkg::*;
();

    localparam int SETTLE_CYCLES  = 160;
    localparam int WATCHDOG_LIMIT = 4000;

    typedef struct packed {
        logic [SCORE_W-1:0] score;
        logic [INDEX_W-1:0] lead;
        logic [INDEX_W-1:0] trail;
        logic               passes;
    } pair_score_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    prs_reg_t             cfg_index;
    logic [SUM_W-1:0]     cfg_data;

    prs_sample_if sample_ch ();
    prs_score_if  score_ch ();

    // scoring state kept alongside the block
    logic                 cfg_weighted       = 1'b0;
    logic [SUM_W-1:0]     cfg_one_total      = SUM_W'(1);
    logic [SUM_W-1:0]     cfg_zero_total     = SUM_W'(1);
    logic [SCORE_W-1:0]   cfg_pass_threshold = '0;
    logic [SUM_W-1:0]     one_sum            = '0;
    logic [SUM_W-1:0]     zero_sum           = '0;

    pair_score_t          expected_scores[$];
    int                   mismatch_count = 0;
    int                   quiet_cycles   = 0;
    int                   tx_idle_pct    = 0;
    int                   rx_stall_pct   = 0;
    int                   stall_left     = 0;

    pair_rank_score u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .samples   (sample_ch),
        .scores    (score_ch)
    );

    always #6 clk = ~clk;

    function automatic int pick_gap();
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [SUM_W-1:0] add_clamped(input logic [SUM_W-1:0] sum,
                                                     input logic [WEIGHT_W-1:0] inc);
        logic [SUM_W:0] total;
        total = {1'b0, sum} + (SUM_W+1)'(inc);
        return total[SUM_W] ? SUM_MAX : total[SUM_W-1:0];
    endfunction

    function automatic logic [QUO_W-1:0] frac_q16(input logic [SUM_W-1:0] sum,
                                                  input logic [SUM_W-1:0] total);
        logic [QUO_W-1:0] num;
        num = {sum, {FRAC_SH{1'b0}}};
        if (total == '0)
            return '0;
        return num / QUO_W'(total);
    endfunction

    function automatic logic signed [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 19))
            0: return 32'sh8000_0000;
            1: return 32'sh7FFF_FFFF;
            2: return 32'sh0000_0000;
            3: return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [WEIGHT_W-1:0] pick_weight();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return WEIGHT_W'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [SUM_W-1:0] pick_total(input logic weighted);
        case ($urandom_range(0, 9))
            0: return '0;
            1: return SUM_MAX;
            2: return SUM_W'(1);
            default: return weighted ? SUM_W'($urandom_range(1, 700000))
                                     : SUM_W'($urandom_range(1, 16));
        endcase
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("[%0t] mismatch %s: got %0d, want %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    // track the sums on every accepted sample transfer and predict the score on the last one
    always @(posedge clk)
    begin : score_predict
        logic [WEIGHT_W-1:0] inc;
        logic [QUO_W-1:0]    f1;
        logic [QUO_W-1:0]    f0;
        logic [QUO_W-1:0]    diff;
        pair_score_t         want;
        if (rst_n === 1'b1 && sample_ch.valid === 1'b1 && sample_ch.ready === 1'b1)
        begin
            inc = cfg_weighted ? sample_ch.weight : WEIGHT_W'(1);
            if ($signed(sample_ch.first_value) < $signed(sample_ch.second_value))
            begin
                if (sample_ch.label)
                    one_sum = add_clamped(one_sum, inc);
                else
                    zero_sum = add_clamped(zero_sum, inc);
            end
            if (sample_ch.last_sample)
            begin
                f1 = frac_q16(one_sum, cfg_one_total);
                f0 = frac_q16(zero_sum, cfg_zero_total);
                if (f1 >= f0)
                begin
                    diff       = f1 - f0;
                    want.lead  = sample_ch.first_index;
                    want.trail = sample_ch.second_index;
                end
                else
                begin
                    diff       = f0 - f1;
                    want.lead  = sample_ch.second_index;
                    want.trail = sample_ch.first_index;
                end
                want.score  = (|diff[QUO_W-1:SCORE_W]) ? SCORE_MAX : diff[SCORE_W-1:0];
                want.passes = (want.score >= cfg_pass_threshold);
                expected_scores.push_back(want);
                one_sum  = '0;
                zero_sum = '0;
            end
        end
    end

    always @(posedge clk)
    begin : score_check
        pair_score_t want;
        if (rst_n === 1'b1 && score_ch.valid === 1'b1 && score_ch.ready === 1'b1)
        begin
            if (expected_scores.size() == 0)
                report_mismatch("score with none pending", longint'(score_ch.pair_score), 0);
            else
            begin
                want = expected_scores.pop_front();
                if (score_ch.pair_score !== want.score)
                    report_mismatch("pair_score", longint'(score_ch.pair_score),
                                    longint'(want.score));
                if (score_ch.lead_index !== want.lead)
                    report_mismatch("lead_index", longint'(score_ch.lead_index),
                                    longint'(want.lead));
                if (score_ch.trail_index !== want.trail)
                    report_mismatch("trail_index", longint'(score_ch.trail_index),
                                    longint'(want.trail));
                if (score_ch.passes !== want.passes)
                    report_mismatch("passes", longint'(score_ch.passes),
                                    longint'(want.passes));
            end
        end
    end

    // score side back-pressure
    always @(posedge clk)
    begin
        if (rst_n !== 1'b1)
        begin
            score_ch.ready <= 1'b0;
            stall_left     <= 0;
        end
        else if (stall_left != 0)
        begin
            score_ch.ready <= 1'b0;
            stall_left     <= stall_left - 1;
        end
        else
        begin
            score_ch.ready <= 1'b1;
            if ($urandom_range(0, 99) < rx_stall_pct)
                stall_left <= pick_gap();
        end
    end

    always @(posedge clk)
    begin
        if (rst_n !== 1'b1 || (sample_ch.valid === 1'b1 && sample_ch.ready === 1'b1)
            || (score_ch.valid === 1'b1 && score_ch.ready === 1'b1))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic send_sample(input logic signed [VALUE_W-1:0] a, b, input logic lbl,
                               input logic [WEIGHT_W-1:0] w,
                               input logic [INDEX_W-1:0] i0, i1, input logic fin);
        int gap;
        gap = ($urandom_range(0, 99) < tx_idle_pct) ? pick_gap() : 0;
        if (gap != 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_ch.valid        <= 1'b1;
        sample_ch.first_value  <= a;
        sample_ch.second_value <= b;
        sample_ch.label        <= lbl;
        sample_ch.weight       <= w;
        sample_ch.first_index  <= i0;
        sample_ch.second_index <= i1;
        sample_ch.last_sample  <= fin;
        do @(posedge clk); while (sample_ch.ready !== 1'b1);
    endtask

    // leaves cfg_we high; the caller lowers it after the last write
    task automatic write_reg(input prs_reg_t idx, input logic [SUM_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            REG_WEIGHTED_MODE:    cfg_weighted       = val[0];
            REG_CLASS_ONE_TOTAL:  cfg_one_total      = val;
            REG_CLASS_ZERO_TOTAL: cfg_zero_total     = val;
            REG_PASS_THRESHOLD:   cfg_pass_threshold = val[SCORE_W-1:0];
            default: ;
        endcase
    endtask

    task automatic load_config(input logic weighted, input logic [SUM_W-1:0] one_total,
                               input logic [SUM_W-1:0] zero_total,
                               input logic [SCORE_W-1:0] threshold);
        write_reg(REG_WEIGHTED_MODE, SUM_W'(weighted));
        write_reg(REG_CLASS_ONE_TOTAL, one_total);
        write_reg(REG_CLASS_ZERO_TOTAL, zero_total);
        write_reg(REG_PASS_THRESHOLD, SUM_W'(threshold));
        cfg_we <= 1'b0;
    endtask

    task automatic wait_idle();
        sample_ch.valid <= 1'b0;
        @(posedge clk);
        while (expected_scores.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // totals of one after reset, so any counted sample brings a fraction up to one
    task automatic test_reset_defaults();
        tx_idle_pct  = 30;
        rx_stall_pct = 30;
        send_sample(-32'sd5, 32'sd7, 1'b1, 16'h1234, 10'd3, 10'd900, 1'b1);
        send_sample(32'sd100, 32'sd200, 1'b0, 16'h0000, 10'd1023, 10'd0, 1'b1);
        send_sample(32'sd42, 32'sd42, 1'b1, 16'hFFFF, 10'd0, 10'd1023, 1'b1);
        wait_idle();
    endtask

    task automatic test_extremes();
        load_config(1'b1, 28'd512, 28'd0, 16'hFFFF);
        send_sample(32'sh8000_0000, 32'sh7FFF_FFFF, 1'b1, 16'hFFFF, 10'd5, 10'd6, 1'b0);
        send_sample(32'sh7FFF_FFFF, 32'sh8000_0000, 1'b1, 16'hFFFF, 10'd7, 10'd8, 1'b0);
        send_sample(-32'sd1, 32'sd0, 1'b0, 16'h0000, 10'd0, 10'd0, 1'b0);
        send_sample(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b1, 16'hFFFF, 10'd1, 10'd2, 1'b0);
        send_sample(32'sd0, 32'sd1, 1'b1, 16'h0100, 10'd1023, 10'd1023, 1'b1);
        wait_idle();
    endtask

    // weights must be ignored in count mode
    task automatic test_ratio_swap();
        load_config(1'b0, 28'd4, 28'd4, 16'd32768);
        repeat (4) send_sample(-32'sd10, 32'sd10, 1'b1, 16'hFFFF, 10'd99, 10'd98, 1'b0);
        send_sample(-32'sd10, 32'sd10, 1'b0, 16'h8000, 10'd97, 10'd96, 1'b0);
        send_sample(32'sd3, 32'sd4, 1'b0, 16'h0001, 10'd12, 10'd34, 1'b1);
        send_sample(32'sd1, 32'sd2, 1'b1, 16'h0000, 10'd0, 10'd0, 1'b0);
        repeat (2) send_sample(32'sd1, 32'sd2, 1'b0, 16'h0000, 10'd0, 10'd0, 1'b0);
        send_sample(32'sd1, 32'sd2, 1'b0, 16'h0000, 10'd50, 10'd60, 1'b1);
        send_sample(32'sd1, 32'sd2, 1'b1, 16'h0000, 10'd70, 10'd80, 1'b1);
        wait_idle();
    endtask

    task automatic test_zero_totals();
        load_config(1'b0, 28'd0, 28'd3, 16'd1);
        send_sample(32'sd1, 32'sd2, 1'b1, 16'h0000, 10'd0, 10'd0, 1'b0);
        send_sample(32'sd1, 32'sd2, 1'b0, 16'h0000, 10'd512, 10'd511, 1'b1);
        wait_idle();
    endtask

    task automatic send_random_pairs(input int n_items);
        int                          sent;
        int                          len;
        logic [INDEX_W-1:0]          i0;
        logic [INDEX_W-1:0]          i1;
        logic signed [VALUE_W-1:0]   a;
        logic signed [VALUE_W-1:0]   b;
        sent = 0;
        while (sent < n_items)
        begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 40) : $urandom_range(1, 10);
            i0  = INDEX_W'($urandom_range(0, 1023));
            i1  = INDEX_W'($urandom_range(0, 1023));
            for (int k = 1; k <= len; k++)
            begin
                a = pick_value();
                b = ($urandom_range(0, 9) == 0) ? a : pick_value();
                if (k == len)
                    send_sample(a, b, 1'($urandom_range(0, 1)), pick_weight(), i0, i1, 1'b1);
                else if ($urandom_range(0, 4) == 0)
                    // indices on earlier samples do not matter
                    send_sample(a, b, 1'($urandom_range(0, 1)), pick_weight(),
                                INDEX_W'($urandom_range(0, 1023)),
                                INDEX_W'($urandom_range(0, 1023)), 1'b0);
                else
                    send_sample(a, b, 1'($urandom_range(0, 1)), pick_weight(), i0, i1, 1'b0);
            end
            sent += len;
        end
    endtask

    task automatic test_random_phases();
        logic weighted;
        int   pct_choice[3];
        pct_choice = '{0, 30, 70};
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0:
                begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 0;
                    load_config(1'b0, pick_total(1'b0), pick_total(1'b0),
                                SCORE_W'($urandom_range(0, 65535)));
                end
                1:
                begin
                    tx_idle_pct  = 10;
                    rx_stall_pct = 70;
                    load_config(1'b1, SUM_W'($urandom_range(1, 700000)),
                                SUM_W'($urandom_range(1, 700000)),
                                SCORE_W'($urandom_range(0, 65535)));
                end
                2:
                begin
                    tx_idle_pct  = 30;
                    rx_stall_pct = 30;
                    load_config(1'b0, 28'd0, SUM_MAX, 16'd0);
                end
                3:
                begin
                    tx_idle_pct  = 70;
                    rx_stall_pct = 0;
                    load_config(1'b1, SUM_MAX, 28'd0, 16'hFFFF);
                end
                4:
                begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 30;
                    load_config(1'b1, 28'd1, 28'd1, 16'd0);
                end
                default:
                begin
                    tx_idle_pct  = pct_choice[$urandom_range(0, 2)];
                    rx_stall_pct = pct_choice[$urandom_range(0, 2)];
                    weighted     = 1'($urandom_range(0, 1));
                    load_config(weighted, pick_total(weighted), pick_total(weighted),
                                SCORE_W'($urandom_range(0, 65535)));
                end
            endcase
            send_random_pairs(130);
            wait_idle();
        end
    endtask

    initial
    begin
        rst_n                  = 1'b0;
        cfg_we                 = 1'b0;
        cfg_index              = REG_WEIGHTED_MODE;
        cfg_data               = '0;
        sample_ch.valid        = 1'b0;
        sample_ch.first_value  = '0;
        sample_ch.second_value = '0;
        sample_ch.label        = 1'b0;
        sample_ch.weight       = '0;
        sample_ch.first_index  = '0;
        sample_ch.second_index = '0;
        sample_ch.last_sample  = 1'b0;
        score_ch.ready         = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_extremes();
        test_ratio_swap();
        test_zero_totals();
        test_random_phases();

        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

[sim.f]
rtl/prs_pkg.sv
rtl/prs_sample_if.sv
rtl/prs_score_if.sv
rtl/prs_front.sv
rtl/prs_queue.sv
rtl/prs_back.sv
rtl/pair_rank_score.sv
sim/pair_rank_score_test.sv
